// ===== sv/aff_pkg.sv =====
`default_nettype none

package aff_pkg;

	localparam int ELEMENT_WIDTH = 32;
	localparam int FRACTION_BITS = 16;

	localparam int PORT_W    = 32;
	localparam int AREG_W    = 64;
	localparam int HALF_W    = AREG_W / 2;
	localparam int NUM_AREG  = 6;
	localparam int CFG_IDX_W = 3;
	localparam int FUNC_W    = 2;

	localparam logic [FUNC_W-1:0] FUNC_COMPOSE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_XFORM   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_UNXFORM = 2'd2;

	typedef logic [AREG_W-1:0] areg_t;

	// identity rotation, zero translation
	localparam areg_t AREG_RESET [NUM_AREG] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	typedef struct packed {
		logic load_s3;
		logic load_s4;
	} aff_lane_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/affine_3x4_transform_unit_core.sv =====
`default_nettype none

// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+---------------------------------------------
// in      | in  | in_valid / in_ready  | func, elem0..elem3, is_translation_column
// out     | out | out_valid / out_ready| out0..out3, saturated
// cfg     | in  | cfg_we (no wait)     | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready is high. Stages up to out_valid:
// input reg, operand select/subtract, 12 parallel multipliers, sum + clamp.
// Reset clears all stage valids and returns A to identity with zero translation.
// A low out_ready freezes stage 4 and back-pressures only up to the first empty
// stage; in_ready drops only when all four stages hold beats and out is stalled.

module affine_3x4_transform_unit_core #(
	parameter int ELEMENT_WIDTH = aff_pkg::ELEMENT_WIDTH,
	parameter int FRACTION_BITS = aff_pkg::FRACTION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [aff_pkg::FUNC_W-1:0]        func,
	input  logic signed [aff_pkg::PORT_W-1:0] elem0,
	input  logic signed [aff_pkg::PORT_W-1:0] elem1,
	input  logic signed [aff_pkg::PORT_W-1:0] elem2,
	input  logic signed [aff_pkg::PORT_W-1:0] elem3,
	input  logic                              is_translation_column,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [aff_pkg::PORT_W-1:0] out0,
	output logic signed [aff_pkg::PORT_W-1:0] out1,
	output logic signed [aff_pkg::PORT_W-1:0] out2,
	output logic signed [aff_pkg::PORT_W-1:0] out3,
	output logic                              saturated,
	input  logic                              cfg_we,
	input  logic [aff_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aff_pkg::AREG_W-1:0]        cfg_data
);

	import aff_pkg::*;

	localparam int EW = ELEMENT_WIDTH;

	areg_t areg_q [NUM_AREG];

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic                 free1, free2, free3, free4;
	logic                 load1, load2, load3, load4;
	aff_lane_ctrl_t       lane_ctrl;

	logic [FUNC_W-1:0]    func_s1;
	logic signed [EW-1:0] elem_s1 [4];
	logic                 trans_s1;

	logic signed [EW-1:0] x_s2 [4][3];
	logic signed [EW:0]   y_s2 [3];
	logic signed [EW-1:0] d_s2 [4];

	logic signed [EW-1:0] res_s4 [4];
	logic [3:0]           sat_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			areg_q <= AREG_RESET;
		end else begin
			for (int i = 0; i < NUM_AREG; i++) begin
				if (cfg_we && cfg_index == CFG_IDX_W'(i)) begin
					areg_q[i] <= cfg_data;
				end
			end
		end
	end

	// a stage is free if empty or its beat moves on this cycle
	assign free4 = !v_s4 || out_ready;
	assign free3 = !v_s3 || free4;
	assign free2 = !v_s2 || free3;
	assign free1 = !v_s1 || free2;
	assign load4 = v_s3 && free4;
	assign load3 = v_s2 && free3;
	assign load2 = v_s1 && free2;
	assign load1 = in_valid && free1;

	assign in_ready  = free1;
	assign out_valid = v_s4;

	assign lane_ctrl.load_s3 = load3;
	assign lane_ctrl.load_s4 = load4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= load1 || (v_s1 && !free2);
			v_s2 <= load2 || (v_s2 && !free3);
			v_s3 <= load3 || (v_s3 && !free4);
			v_s4 <= load4 || (v_s4 && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			func_s1    <= func;
			elem_s1[0] <= elem0[EW-1:0];
			elem_s1[1] <= elem1[EW-1:0];
			elem_s1[2] <= elem2[EW-1:0];
			elem_s1[3] <= elem3[EW-1:0];
			trans_s1   <= is_translation_column;
		end
	end

	aff_operand #(
		.EW(EW)
	) u_operand (
		.clk     (clk),
		.load    (load2),
		.func_s1 (func_s1),
		.elem_s1 (elem_s1),
		.trans_s1(trans_s1),
		.areg    (areg_q),
		.x_s2    (x_s2),
		.y_s2    (y_s2),
		.d_s2    (d_s2)
	);

	for (genvar j = 0; j < 4; j++) begin : g_lane
		aff_lane #(
			.EW(EW),
			.FB(FRACTION_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (lane_ctrl),
			.x     (x_s2[j]),
			.y     (y_s2),
			.d     (d_s2[j]),
			.res_s4(res_s4[j]),
			.sat_s4(sat_s4[j])
		);
	end

	assign out0      = PORT_W'(res_s4[0]);
	assign out1      = PORT_W'(res_s4[1]);
	assign out2      = PORT_W'(res_s4[2]);
	assign out3      = PORT_W'(res_s4[3]);
	assign saturated = |sat_s4;

`ifndef ASSERT_OFF
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !(v_s1 && v_s2 && v_s3 && v_s4 && !out_ready))
		else $error("in_ready does not match pipeline occupancy");

	a_lane3_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load2 && func_s1 != FUNC_COMPOSE) |=>
		(x_s2[3][0] == '0 && x_s2[3][1] == '0 && x_s2[3][2] == '0 && d_s2[3] == '0))
		else $error("translation lane has operands outside compose");
`endif

endmodule

`default_nettype wire

// ===== sv/aff_operand.sv =====
`default_nettype none

module aff_operand #(
	parameter int EW = aff_pkg::ELEMENT_WIDTH
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [aff_pkg::FUNC_W-1:0]    func_s1,
	input  logic signed [EW-1:0]          elem_s1 [4],
	input  logic                          trans_s1,
	input  aff_pkg::areg_t                areg [aff_pkg::NUM_AREG],
	output logic signed [EW-1:0]          x_s2 [4][3],
	output logic signed [EW:0]            y_s2 [3],
	output logic signed [EW-1:0]          d_s2 [4]
);

	import aff_pkg::*;

	logic signed [EW-1:0] a_mat [3][4];
	logic signed [EW-1:0] x_c [4][3];
	logic signed [EW:0]   y_c [3];
	logic signed [EW-1:0] d_c [4];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				a_mat[r][c] = areg[r * 2 + (c >> 1)][(c & 1) * HALF_W +: EW];
			end
		end
	end

	// x always comes from A, y from the input beat; lane j builds out_j
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			d_c[j] = '0;
			for (int k = 0; k < 3; k++) begin
				x_c[j][k] = '0;
			end
		end
		for (int k = 0; k < 3; k++) begin
			if (func_s1 == FUNC_UNXFORM && trans_s1) begin
				y_c[k] = (EW+1)'(elem_s1[k]) - (EW+1)'(a_mat[k][3]);
			end else begin
				y_c[k] = (EW+1)'(elem_s1[k]);
			end
		end
		case (func_s1)
			FUNC_COMPOSE: begin
				for (int j = 0; j < 4; j++) begin
					for (int k = 0; k < 3; k++) begin
						x_c[j][k] = a_mat[k][j];
					end
				end
				d_c[3] = elem_s1[3];
			end
			FUNC_XFORM: begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						x_c[j][k] = a_mat[j][k];
					end
					if (trans_s1) begin
						d_c[j] = a_mat[j][3];
					end
				end
			end
			FUNC_UNXFORM: begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						x_c[j][k] = a_mat[k][j];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_s2 <= x_c;
			y_s2 <= y_c;
			d_s2 <= d_c;
		end
	end

endmodule

`default_nettype wire

// ===== sv/aff_lane.sv =====
`default_nettype none

module aff_lane #(
	parameter int EW = aff_pkg::ELEMENT_WIDTH,
	parameter int FB = aff_pkg::FRACTION_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  aff_pkg::aff_lane_ctrl_t ctrl,
	input  logic signed [EW-1:0]    x [3],
	input  logic signed [EW:0]      y [3],
	input  logic signed [EW-1:0]    d,
	output logic signed [EW-1:0]    res_s4,
	output logic                    sat_s4
);

	import aff_pkg::*;

	localparam int PW = 2 * EW + 1;
	localparam int QW = PW - FB;
	localparam int SW = QW + 2;

	localparam logic signed [EW-1:0] MAX_E = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] MIN_E = {1'b1, {(EW-1){1'b0}}};

	logic signed [PW-1:0] prod [3];
	logic signed [QW-1:0] p_s3 [3];
	logic signed [EW-1:0] d_s3;
	logic signed [SW-1:0] sum;
	logic signed [EW-1:0] res_c;
	logic                 sat_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = PW'(x[k]) * PW'(y[k]);
		end
	end

	// dropping the low fraction bits is the floor shift
	always_ff @(posedge clk) begin
		if (ctrl.load_s3) begin
			for (int k = 0; k < 3; k++) begin
				p_s3[k] <= prod[k][PW-1:FB];
			end
			d_s3 <= d;
		end
	end

	always_comb begin
		sum = SW'(p_s3[0]) + SW'(p_s3[1]) + SW'(p_s3[2]) + SW'(d_s3);
		sat_c = 1'b0;
		if (sum > SW'(MAX_E)) begin
			res_c = MAX_E;
			sat_c = 1'b1;
		end else if (sum < SW'(MIN_E)) begin
			res_c = MIN_E;
			sat_c = 1'b1;
		end else begin
			res_c = sum[EW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s4) begin
			res_s4 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_s4 <= 1'b0;
		end else if (ctrl.load_s4) begin
			sat_s4 <= sat_c;
		end
	end

`ifndef ASSERT_OFF
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		sat_s4 |-> (res_s4 == MAX_E || res_s4 == MIN_E))
		else $error("saturation flag set on an unclamped result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import aff_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int RUN_LIMIT = 400000;
	localparam int SHOW_LIMIT = 10;

	localparam logic [31:0] Q_MAX     = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN     = 32'h8000_0000;
	localparam logic [31:0] Q_ONE     = 32'h0001_0000;
	localparam logic [31:0] Q_NEG_ONE = 32'hffff_0000;

	typedef struct packed {
		logic [FUNC_W-1:0]    op;
		logic [3:0][31:0]     e;
		logic                 tr;
	} piece_beat_t;

	typedef struct packed {
		logic [3:0][31:0]     o;
		logic                 sat;
	} xf_row_t;

	typedef enum int {EK_FULL, EK_SMALL, EK_MAX, EK_MIN, EK_ZERO, EK_ONE, EK_NEG_ONE} elem_kind_t;
	typedef enum int {MK_FULL, MK_SMALL, MK_MAX, MK_MIN, MK_ZERO, MK_IDENT, MK_MIXED} mat_kind_t;

	class affine_predictor;
		areg_t   coef [NUM_AREG];
		xf_row_t expected_rows [$];
		int      errors;

		function new();
			foreach (coef[i])
				coef[i] = AREG_RESET[i];
			errors = 0;
		endfunction

		function void cfg_write(int idx, areg_t data);
			if (idx < NUM_AREG)
				coef[idx] = data;
		endfunction

		function longint elem_at(int r, int c);
			areg_t       word;
			logic [31:0] half;
			word = coef[r * 2 + c / 2];
			half = (c % 2) ? word[63:32] : word[31:0];
			return longint'($signed(half));
		endfunction

		function longint mulq(longint a, longint b);
			longint p;
			p = a * b;
			return p >>> FRACTION_BITS;
		endfunction

		function void note_beat(piece_beat_t b);
			longint  el [4];
			longint  w [3];
			longint  s [4];
			longint  hi;
			xf_row_t r;
			hi = 64'sd2147483647;
			r = '0;
			for (int i = 0; i < 4; i++) begin
				el[i] = longint'($signed(b.e[i]));
				s[i] = 0;
			end
			case (b.op)
				FUNC_COMPOSE: begin
					for (int i = 0; i < 4; i++)
						for (int k = 0; k < 3; k++)
							s[i] += mulq(el[k], elem_at(k, i));
					s[3] += el[3];
				end
				FUNC_XFORM: begin
					for (int i = 0; i < 3; i++) begin
						for (int k = 0; k < 3; k++)
							s[i] += mulq(elem_at(i, k), el[k]);
						if (b.tr)
							s[i] += elem_at(i, 3);
					end
				end
				FUNC_UNXFORM: begin
					// difference stays exact, one bit wider than an element
					for (int k = 0; k < 3; k++)
						w[k] = b.tr ? el[k] - elem_at(k, 3) : el[k];
					for (int i = 0; i < 3; i++)
						for (int k = 0; k < 3; k++)
							s[i] += mulq(elem_at(k, i), w[k]);
				end
				default: begin
				end
			endcase
			for (int i = 0; i < 4; i++) begin
				if (s[i] > hi) begin
					s[i] = hi;
					r.sat = 1'b1;
				end else if (s[i] < -hi - 1) begin
					s[i] = -hi - 1;
					r.sat = 1'b1;
				end
				r.o[i] = 32'(s[i]);
			end
			expected_rows.push_back(r);
		endfunction

		function void check_row(xf_row_t got);
			xf_row_t want;
			if (expected_rows.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("unexpected result beat: %h %h %h %h sat %b",
						got.o[0], got.o[1], got.o[2], got.o[3], got.sat);
				return;
			end
			want = expected_rows.pop_front();
			if (got.o[0] !== want.o[0] || got.o[1] !== want.o[1] || got.o[2] !== want.o[2] ||
				got.o[3] !== want.o[3] || got.sat !== want.sat) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("result beat differs: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
						want.o[0], want.o[1], want.o[2], want.o[3], want.sat,
						got.o[0], got.o[1], got.o[2], got.o[3], got.sat);
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [FUNC_W-1:0]        func = FUNC_COMPOSE;
	logic signed [PORT_W-1:0] elem0 = '0;
	logic signed [PORT_W-1:0] elem1 = '0;
	logic signed [PORT_W-1:0] elem2 = '0;
	logic signed [PORT_W-1:0] elem3 = '0;
	logic                     is_translation_column = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [PORT_W-1:0] out0;
	logic signed [PORT_W-1:0] out1;
	logic signed [PORT_W-1:0] out2;
	logic signed [PORT_W-1:0] out3;
	logic                     saturated;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [AREG_W-1:0]        cfg_data = '0;

	affine_predictor chk = new();
	xf_row_t         got_row;

	affine_3x4_transform_unit_core DUT (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_ready              (in_ready),
		.func                  (func),
		.elem0                 (elem0),
		.elem1                 (elem1),
		.elem2                 (elem2),
		.elem3                 (elem3),
		.is_translation_column (is_translation_column),
		.out_valid             (out_valid),
		.out_ready             (out_ready),
		.out0                  (out0),
		.out1                  (out1),
		.out2                  (out2),
		.out3                  (out3),
		.saturated             (saturated),
		.cfg_we                (cfg_we),
		.cfg_index             (cfg_index),
		.cfg_data              (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] rand_elem(elem_kind_t k);
		case (k)
			EK_FULL:    return $urandom;
			EK_SMALL:   return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			EK_MAX:     return Q_MAX;
			EK_MIN:     return Q_MIN;
			EK_ZERO:    return '0;
			EK_ONE:     return Q_ONE;
			default:    return Q_NEG_ONE;
		endcase
	endfunction

	function automatic logic [31:0] item_elem();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return rand_elem(EK_FULL);
		if (r < 8)
			return rand_elem(EK_SMALL);
		return rand_elem(elem_kind_t'($urandom_range(EK_MAX, EK_NEG_ONE)));
	endfunction

	function automatic piece_beat_t make_beat(logic [FUNC_W-1:0] op, logic [31:0] a,
		logic [31:0] b, logic [31:0] c, logic [31:0] d, logic tr);
		piece_beat_t x;
		x.op = op;
		x.e[0] = a;
		x.e[1] = b;
		x.e[2] = c;
		x.e[3] = d;
		x.tr = tr;
		return x;
	endfunction

	function automatic piece_beat_t random_beat();
		logic [FUNC_W-1:0] op;
		int                r;
		r = $urandom_range(0, 15);
		if (r == 0)
			op = FUNC_UNUSED;
		else if (r % 3 == 0)
			op = FUNC_COMPOSE;
		else if (r % 3 == 1)
			op = FUNC_XFORM;
		else
			op = FUNC_UNXFORM;
		return make_beat(op, item_elem(), item_elem(), item_elem(), item_elem(),
			1'($urandom_range(0, 1)));
	endfunction

	task automatic send_beat(piece_beat_t b);
		int gap;
		in_valid <= 1'b1;
		func <= b.op;
		elem0 <= b.e[0];
		elem1 <= b.e[1];
		elem2 <= b.e[2];
		elem3 <= b.e[3];
		is_translation_column <= b.tr;
		do
			@(posedge clk);
		while (!in_ready);
		chk.note_beat(b);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender holds off until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (chk.expected_rows.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic fill_matrix(mat_kind_t kind);
		logic [31:0] a [3][4];
		areg_t       m [NUM_AREG];
		areg_t       junk;
		elem_kind_t  ek;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				case (kind)
					MK_FULL:  ek = EK_FULL;
					MK_SMALL: ek = EK_SMALL;
					MK_MAX:   ek = EK_MAX;
					MK_MIN:   ek = EK_MIN;
					MK_ZERO:  ek = EK_ZERO;
					MK_IDENT: ek = (c == 3) ? EK_FULL : ((c == r) ? EK_ONE : EK_ZERO);
					default:  ek = elem_kind_t'($urandom_range(EK_FULL, EK_NEG_ONE));
				endcase
				a[r][c] = rand_elem(ek);
			end
			m[r * 2]     = {a[r][1], a[r][0]};
			m[r * 2 + 1] = {a[r][3], a[r][2]};
		end
		for (int i = 0; i < NUM_AREG; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= m[i];
			chk.cfg_write(i, m[i]);
			@(posedge clk);
		end
		// indexes past the last register must be ignored
		junk = {$urandom, $urandom};
		cfg_index <= CFG_IDX_W'(NUM_AREG + $urandom_range(0, 1));
		cfg_data <= junk;
		chk.cfg_write(NUM_AREG, junk);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : rx_side
		int run;
		int gap;
		forever begin
			if ($urandom_range(0, 19) == 0) begin
				run = $urandom_range(100, 300);
				gap = 0;
			end else begin
				run = $urandom_range(1, 30);
				gap = pick_gap();
			end
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			got_row.o[0] = out0;
			got_row.o[1] = out1;
			got_row.o[2] = out2;
			got_row.o[3] = out3;
			got_row.sat = saturated;
			chk.check_row(got_row);
		end
	end

	initial begin : watchdog
		repeat (RUN_LIMIT) @(posedge clk);
		$display("affine_3x4_transform_unit_core: mismatch");
		$finish;
	end

	initial begin : stimulus
		mat_kind_t plan [8];
		plan = '{MK_SMALL, MK_FULL, MK_IDENT, MK_MIXED, MK_MAX, MK_MIN, MK_ZERO, MK_MIXED};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset matrix: identity, zero translation; every select incl. the unused one
		for (int f = 0; f < 4; f++) begin
			send_beat(make_beat(FUNC_W'(f), Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
			send_beat(make_beat(FUNC_W'(f), Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
			send_beat(make_beat(FUNC_W'(f), Q_MAX, Q_MIN, Q_NEG_ONE, Q_ONE, 1'b1));
		end
		drain();

		// extreme matrices drive the clamp and the wide untransform difference
		fill_matrix(MK_MAX);
		for (int f = 0; f < 3; f++) begin
			send_beat(make_beat(FUNC_W'(f), Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1));
			send_beat(make_beat(FUNC_W'(f), Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b0));
		end
		drain();
		fill_matrix(MK_MIN);
		for (int f = 0; f < 3; f++) begin
			send_beat(make_beat(FUNC_W'(f), Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
			send_beat(make_beat(FUNC_W'(f), Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
		end
		drain();

		foreach (plan[p]) begin
			fill_matrix(plan[p]);
			repeat (75) send_beat(random_beat());
			drain();
		end

		repeat (10) @(posedge clk);
		if (chk.errors == 0 && chk.expected_rows.size() == 0)
			$display("affine_3x4_transform_unit_core: match");
		else
			$display("affine_3x4_transform_unit_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/aff_pkg.sv
sv/aff_operand.sv
sv/aff_lane.sv
sv/affine_3x4_transform_unit_core.sv
tb/sv/testbench.sv
